/* rtl/core/mfpr_pkg.sv */
package mfpr_pkg;

  localparam int BUF_DEPTH   = 64;
  localparam int BUF_AW      = $clog2(BUF_DEPTH);
  localparam int BYTE_W      = 8;
  localparam int LIMIT_W     = 7;
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  localparam logic [BUF_AW-1:0] FILL_MAX = BUF_AW'(BUF_DEPTH - 2);

  localparam logic [BYTE_W-1:0] START_MARKER_RESET = 8'h40;
  localparam logic [BYTE_W-1:0] END_MARKER_RESET   = 8'h23;

  typedef enum logic {
    CFG_START_MARKER,
    CFG_END_MARKER
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ITEM_START,
    ITEM_END,
    ITEM_DATA,
    ITEM_FETCH
  } item_kind_t;

  typedef struct packed {
    item_kind_t              kind;
    logic [BYTE_W-1:0]       data;
    logic [BUF_AW-1:0]       allow;
  } item_t;

endpackage

/* rtl/core/mfpr_front.sv */
module mfpr_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          action,
  input  logic [mfpr_pkg::BYTE_W-1:0]   rx_byte,
  input  logic [mfpr_pkg::LIMIT_W-1:0]  fetch_limit,
  input  logic                          cfg_write,
  input  logic                          cfg_index,
  input  logic [mfpr_pkg::BYTE_W-1:0]   cfg_data,
  output logic                          q_valid,
  input  logic                          q_ready,
  output mfpr_pkg::item_t               q_item
);

  logic [mfpr_pkg::BYTE_W-1:0]   start_marker;
  logic [mfpr_pkg::BYTE_W-1:0]   end_marker;
  mfpr_pkg::item_t               entry [mfpr_pkg::QUEUE_DEPTH];
  logic [mfpr_pkg::QUEUE_AW-1:0] wr_ptr;
  logic [mfpr_pkg::QUEUE_AW-1:0] rd_ptr;
  logic [mfpr_pkg::QUEUE_CW-1:0] count;
  mfpr_pkg::item_t               item_in;
  logic [mfpr_pkg::LIMIT_W-1:0]  limit_dec;
  logic                          push;
  logic                          pop;

  // The caller may take at most limit minus one bytes; a held packet is never
  // longer than the buffer minus one, so the allowance saturates there.
  always_comb begin
    limit_dec     = fetch_limit - mfpr_pkg::LIMIT_W'(1);
    item_in.data  = rx_byte;
    if (fetch_limit == '0) begin
      item_in.allow = '0;
    end else if (limit_dec > mfpr_pkg::LIMIT_W'(mfpr_pkg::BUF_DEPTH - 1)) begin
      item_in.allow = mfpr_pkg::BUF_AW'(mfpr_pkg::BUF_DEPTH - 1);
    end else begin
      item_in.allow = limit_dec[mfpr_pkg::BUF_AW-1:0];
    end
    // The start marker is tested first, so it wins when both markers match.
    if (action) begin
      item_in.kind = mfpr_pkg::ITEM_FETCH;
    end else if (rx_byte == start_marker) begin
      item_in.kind = mfpr_pkg::ITEM_START;
    end else if (rx_byte == end_marker) begin
      item_in.kind = mfpr_pkg::ITEM_END;
    end else begin
      item_in.kind = mfpr_pkg::ITEM_DATA;
    end
  end

  assign in_ready = (count != mfpr_pkg::QUEUE_CW'(mfpr_pkg::QUEUE_DEPTH));
  assign q_valid  = (count != '0);
  assign q_item   = entry[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_marker <= mfpr_pkg::START_MARKER_RESET;
      end_marker   <= mfpr_pkg::END_MARKER_RESET;
      wr_ptr       <= '0;
      rd_ptr       <= '0;
      count        <= '0;
    end else begin
      if (cfg_write) begin
        unique case (mfpr_pkg::cfg_reg_t'(cfg_index))
          mfpr_pkg::CFG_START_MARKER: start_marker <= cfg_data;
          mfpr_pkg::CFG_END_MARKER:   end_marker   <= cfg_data;
        endcase
      end
      if (push) begin
        wr_ptr <= wr_ptr + mfpr_pkg::QUEUE_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + mfpr_pkg::QUEUE_AW'(1);
      end
      if (push && !pop) begin
        count <= count + mfpr_pkg::QUEUE_CW'(1);
      end else if (pop && !push) begin
        count <= count - mfpr_pkg::QUEUE_CW'(1);
      end
    end
  end

endmodule

/* rtl/core/mfpr_back.sv */
module mfpr_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_valid,
  output logic                         q_ready,
  input  mfpr_pkg::item_t              q_item,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         packet_found,
  output logic                         has_byte,
  output logic [mfpr_pkg::BYTE_W-1:0]  data_byte,
  output logic                         last
);

  typedef enum logic {
    S_IDLE,
    S_STREAM
  } state_t;

  state_t                       state;
  logic                         in_frame;
  logic [mfpr_pkg::BUF_AW-1:0]  fill;
  logic                         zero_seen;
  logic [mfpr_pkg::BUF_AW-1:0]  zero_pos;
  logic [mfpr_pkg::BUF_AW-1:0]  str_len;
  logic                         held;
  logic [mfpr_pkg::BUF_AW-1:0]  rd_idx;
  logic [mfpr_pkg::BUF_AW-1:0]  len_reg;
  logic                         pend_valid;
  logic                         pend_found;
  logic                         pend_has;
  logic                         pend_last;

  logic [mfpr_pkg::BYTE_W-1:0]  mem [mfpr_pkg::BUF_DEPTH];
  logic [mfpr_pkg::BYTE_W-1:0]  mem_q;
  logic                         mem_we;
  logic                         mem_re;
  logic [mfpr_pkg::BUF_AW-1:0]  mem_ra;

  logic                         pend_move;
  logic                         pend_load;
  logic                         can_load;
  logic                         take;
  logic [mfpr_pkg::BUF_AW-1:0]  fetch_len;
  logic                         stream_last;

  assign pend_move   = pend_valid && (!out_valid || out_ready);
  assign can_load    = !pend_valid || pend_move;
  assign fetch_len   = (str_len > q_item.allow) ? q_item.allow : str_len;
  assign q_ready     = (state == S_IDLE) &&
                       ((q_item.kind != mfpr_pkg::ITEM_FETCH) || can_load);
  assign take        = q_valid && q_ready;
  assign stream_last = (rd_idx == len_reg - mfpr_pkg::BUF_AW'(1));
  assign pend_load   = (take && q_item.kind == mfpr_pkg::ITEM_FETCH) ||
                       (state == S_STREAM && can_load);

  always_comb begin
    mem_we = 1'b0;
    mem_re = 1'b0;
    mem_ra = rd_idx;
    if (take && !held && in_frame) begin
      if (q_item.kind == mfpr_pkg::ITEM_END) begin
        mem_we = 1'b1;
      end else if (q_item.kind == mfpr_pkg::ITEM_DATA && fill < mfpr_pkg::FILL_MAX) begin
        mem_we = 1'b1;
      end
    end
    if (take && q_item.kind == mfpr_pkg::ITEM_FETCH && held && fetch_len != '0) begin
      mem_re = 1'b1;
      mem_ra = '0;
    end
    if (state == S_STREAM && can_load) begin
      mem_re = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[fill] <= q_item.data;
    end
    if (mem_re) begin
      mem_q <= mem[mem_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      in_frame   <= 1'b0;
      fill       <= '0;
      zero_seen  <= 1'b0;
      zero_pos   <= '0;
      str_len    <= '0;
      held       <= 1'b0;
      rd_idx     <= '0;
      len_reg    <= '0;
      pend_valid <= 1'b0;
      pend_found <= 1'b0;
      pend_has   <= 1'b0;
      pend_last  <= 1'b0;
      out_valid  <= 1'b0;
      packet_found <= 1'b0;
      has_byte   <= 1'b0;
      data_byte  <= '0;
      last       <= 1'b0;
    end else begin
      if (pend_move) begin
        out_valid    <= 1'b1;
        packet_found <= pend_found;
        has_byte     <= pend_has;
        data_byte    <= pend_has ? mem_q : '0;
        last         <= pend_last;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      if (pend_load) begin
        pend_valid <= 1'b1;
      end else if (pend_move) begin
        pend_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (take) begin
            unique case (q_item.kind)
              mfpr_pkg::ITEM_START: begin
                if (!held) begin
                  in_frame  <= 1'b1;
                  fill      <= '0;
                  zero_seen <= 1'b0;
                end
              end
              mfpr_pkg::ITEM_END: begin
                if (!held && in_frame) begin
                  held     <= 1'b1;
                  in_frame <= 1'b0;
                  fill     <= '0;
                  if (zero_seen) begin
                    str_len <= zero_pos;
                  end else if (q_item.data == '0) begin
                    str_len <= fill;
                  end else begin
                    str_len <= fill + mfpr_pkg::BUF_AW'(1);
                  end
                end
              end
              mfpr_pkg::ITEM_DATA: begin
                if (!held && in_frame) begin
                  if (fill < mfpr_pkg::FILL_MAX) begin
                    fill <= fill + mfpr_pkg::BUF_AW'(1);
                    if (q_item.data == '0 && !zero_seen) begin
                      zero_seen <= 1'b1;
                      zero_pos  <= fill;
                    end
                  end else begin
                    in_frame <= 1'b0;
                    fill     <= '0;
                  end
                end
              end
              mfpr_pkg::ITEM_FETCH: begin
                if (!held) begin
                  pend_found <= 1'b0;
                  pend_has   <= 1'b0;
                  pend_last  <= 1'b1;
                end else begin
                  held       <= 1'b0;
                  pend_found <= 1'b1;
                  if (fetch_len == '0) begin
                    pend_has  <= 1'b0;
                    pend_last <= 1'b1;
                  end else begin
                    pend_has  <= 1'b1;
                    pend_last <= (fetch_len == mfpr_pkg::BUF_AW'(1));
                    if (fetch_len != mfpr_pkg::BUF_AW'(1)) begin
                      state   <= S_STREAM;
                      rd_idx  <= mfpr_pkg::BUF_AW'(1);
                      len_reg <= fetch_len;
                    end
                  end
                end
              end
            endcase
          end
        end
        S_STREAM: begin
          if (can_load) begin
            pend_found <= 1'b1;
            pend_has   <= 1'b1;
            pend_last  <= stream_last;
            rd_idx     <= rd_idx + mfpr_pkg::BUF_AW'(1);
            if (stream_last) begin
              state <= S_IDLE;
            end
          end
        end
      endcase
    end
  end

endmodule

/* rtl/core/marker_framed_packet_receiver.sv */
// Channel  | Handshake            | Payload
// ---------+----------------------+------------------------------------------------
// in       | in_valid / in_ready  | action, rx_byte, fetch_limit
// out      | out_valid/ out_ready | packet_found, has_byte, data_byte, last
// cfg      | cfg_write            | cfg_index, cfg_data
//
// A received byte is taken by the frame engine and gives no transaction out.
// A fetch gives one result per cycle while out_ready is high; the first result
// passes through the two-entry queue, the pending result and packet memory read
// registers, and the output register.
// Reset sets the markers to their defaults and clears all control state; the
// packet memory is not cleared. An output stall can back up into the input.
module marker_framed_packet_receiver (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          action,
  input  logic [mfpr_pkg::BYTE_W-1:0]   rx_byte,
  input  logic [mfpr_pkg::LIMIT_W-1:0]  fetch_limit,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          packet_found,
  output logic                          has_byte,
  output logic [mfpr_pkg::BYTE_W-1:0]   data_byte,
  output logic                          last,
  input  logic                          cfg_write,
  input  logic                          cfg_index,
  input  logic [mfpr_pkg::BYTE_W-1:0]   cfg_data
);

  logic            q_valid;
  logic            q_ready;
  mfpr_pkg::item_t q_item;

  mfpr_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .action      (action),
    .rx_byte     (rx_byte),
    .fetch_limit (fetch_limit),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .q_valid     (q_valid),
    .q_ready     (q_ready),
    .q_item      (q_item)
  );

  mfpr_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_ready      (q_ready),
    .q_item       (q_item),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .packet_found (packet_found),
    .has_byte     (has_byte),
    .data_byte    (data_byte),
    .last         (last)
  );

endmodule

/* tb/sv/marker_framed_packet_receiver_checker.sv */
`timescale 1ns / 100ps

module marker_framed_packet_receiver_checker
  import mfpr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic              action,
  input  logic [BYTE_W-1:0] rx_byte,
  input  logic [LIMIT_W-1:0] fetch_limit,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic              packet_found,
  input  logic              has_byte,
  input  logic [BYTE_W-1:0] data_byte,
  input  logic              last,
  input  logic              cfg_write,
  input  logic              cfg_index,
  input  logic [BYTE_W-1:0] cfg_data,
  output int                fail_count,
  output int                pending_count
);

  typedef struct packed {
    logic              found;
    logic              has;
    logic [BYTE_W-1:0] data;
    logic              fin;
  } packet_beat_t;

  logic [BYTE_W-1:0] start_mark;
  logic [BYTE_W-1:0] end_mark;
  logic              framing;
  int unsigned       fill;
  logic [BYTE_W-1:0] frame_buf [BUF_DEPTH];
  logic [BYTE_W-1:0] ready_buf [BUF_DEPTH];
  int unsigned       ready_len;
  logic              held;
  packet_beat_t      beat_q [$];

  task automatic clear_frame();
    for (int i = 0; i < BUF_DEPTH; i++) frame_buf[i] = '0;
  endtask

  task automatic take_rx_byte(input logic [BYTE_W-1:0] b);
    if (held) return;
    if (b == start_mark) begin
      framing = 1'b1;
      fill = 0;
      clear_frame();
    end else if (framing && b == end_mark) begin
      frame_buf[fill % BUF_DEPTH] = end_mark;
      for (int i = 0; i <= fill; i++) ready_buf[i] = frame_buf[i];
      ready_len = fill + 1;
      held = 1'b1;
      framing = 1'b0;
      fill = 0;
    end else if (framing) begin
      if (fill < BUF_DEPTH - 2) begin
        frame_buf[fill] = b;
        fill++;
      end else begin
        framing = 1'b0;
        fill = 0;
        clear_frame();
      end
    end
  endtask

  task automatic serve_fetch(input logic [LIMIT_W-1:0] lim);
    int unsigned n;
    int unsigned allow;
    if (!held) begin
      beat_q.push_back('{1'b0, 1'b0, 8'h00, 1'b1});
      return;
    end
    n = 0;
    while (n < ready_len && n < BUF_DEPTH && ready_buf[n] != 8'h00) n++;
    allow = (lim == 0) ? 0 : lim - 1;
    if (n > allow) n = allow;
    held = 1'b0;
    ready_len = 0;
    if (n == 0) begin
      beat_q.push_back('{1'b1, 1'b0, 8'h00, 1'b1});
    end else begin
      for (int k = 0; k < n; k++) beat_q.push_back('{1'b1, 1'b1, ready_buf[k], k + 1 == n});
    end
  endtask

  task automatic check_field(input string name, input logic [BYTE_W-1:0] want,
                             input logic [BYTE_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    packet_beat_t want;
    if (rst) begin
      start_mark = START_MARKER_RESET;
      end_mark   = END_MARKER_RESET;
      framing    = 1'b0;
      fill       = 0;
      ready_len  = 0;
      held       = 1'b0;
      fail_count = 0;
      clear_frame();
      beat_q.delete();
    end else begin
      if (cfg_write) begin
        if (cfg_index == CFG_START_MARKER) start_mark = cfg_data;
        else end_mark = cfg_data;
      end
      if (in_valid && in_ready) begin
        if (action) serve_fetch(fetch_limit);
        else take_rx_byte(rx_byte);
      end
      if (out_valid && out_ready) begin
        if (beat_q.size() == 0) begin
          $error("result transaction with nothing expected: data_byte %0h", data_byte);
          fail_count++;
        end else begin
          want = beat_q.pop_front();
          check_field("packet_found", 8'(want.found), 8'(packet_found));
          check_field("has_byte", 8'(want.has), 8'(has_byte));
          check_field("data_byte", want.data, data_byte);
          check_field("last", 8'(want.fin), 8'(last));
        end
      end
    end
    pending_count = beat_q.size();
  end

endmodule

/* tb/sv/marker_framed_packet_receiver_tb.sv */
`timescale 1ns / 100ps

module marker_framed_packet_receiver_tb;
  import mfpr_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic               action;
  logic [BYTE_W-1:0]  rx_byte;
  logic [LIMIT_W-1:0] fetch_limit;
  logic               out_valid;
  logic               out_ready;
  logic               packet_found;
  logic               has_byte;
  logic [BYTE_W-1:0]  data_byte;
  logic               last;
  logic               cfg_write;
  logic               cfg_index;
  logic [BYTE_W-1:0]  cfg_data;
  int                 fail_count;
  int                 pending_count;

  int                 idle_cycles;
  int                 stall_left;
  logic               quiet;
  logic [BYTE_W-1:0]  cur_start;
  logic [BYTE_W-1:0]  cur_end;

  marker_framed_packet_receiver u_top (.*);

  marker_framed_packet_receiver_checker u_checker (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(0, 15);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic send_item(input logic act, input logic [BYTE_W-1:0] b,
                           input logic [LIMIT_W-1:0] lim);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    in_valid    <= 1'b1;
    action      <= act;
    rx_byte     <= b;
    fetch_limit <= lim;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_rx(input logic [BYTE_W-1:0] b);
    send_item(1'b0, b, 7'($urandom_range(0, 127)));
  endtask

  task automatic send_fetch(input logic [LIMIT_W-1:0] lim);
    send_item(1'b1, 8'($urandom_range(0, 255)), lim);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_count != 0);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [BYTE_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
    if (idx == CFG_START_MARKER) cur_start = val;
    else cur_end = val;
  endtask

  function automatic logic [BYTE_W-1:0] pick_data();
    logic [BYTE_W-1:0] b;
    b = ($urandom_range(0, 19) == 0) ? 8'h00 : 8'($urandom_range(0, 255));
    while (b == cur_start || b == cur_end) b = 8'($urandom_range(0, 255));
    return b;
  endfunction

  function automatic logic [LIMIT_W-1:0] pick_limit();
    case ($urandom_range(0, 7))
      0:       return 7'($urandom_range(0, 127));
      1:       return 7'($urandom_range(1, 4));
      default: return 7'($urandom_range(1, 64));
    endcase
  endfunction

  task automatic send_frame(input int len);
    send_rx(cur_start);
    repeat (len) send_rx(pick_data());
    send_rx(cur_end);
  endtask

  task automatic random_burst(input int target);
    int sent;
    int len;
    sent = 0;
    while (sent < target) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          len = $urandom_range(0, 12);
          send_frame(len);
          if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) send_rx(pick_data());
          if ($urandom_range(0, 5) == 0) send_frame($urandom_range(0, 3));
          send_fetch(pick_limit());
          sent += len + 3;
        end
        5: begin
          len = $urandom_range(58, 64);
          send_frame(len);
          send_fetch(($urandom_range(0, 1) == 0) ? 7'd127 : pick_limit());
          sent += len + 3;
        end
        6: begin
          len = $urandom_range(0, 5);
          send_rx(cur_start);
          repeat (len) send_rx(pick_data());
          if ($urandom_range(0, 1) == 0) send_rx(cur_end);
          sent += len + 1;
        end
        7: repeat ($urandom_range(1, 4)) send_rx(8'($urandom_range(0, 255)));
        8: begin
          send_fetch(pick_limit());
          sent++;
        end
        default: drain();
      endcase
    end
  endtask

  initial begin
    clk         = 1'b0;
    rst         = 1'b1;
    in_valid    = 1'b0;
    action      = 1'b0;
    rx_byte     = '0;
    fetch_limit = '0;
    out_ready   = 1'b0;
    cfg_write   = 1'b0;
    cfg_index   = CFG_START_MARKER;
    cfg_data    = '0;
    quiet       = 1'b0;
    stall_left  = 0;
    idle_cycles = 0;
    cur_start   = START_MARKER_RESET;
    cur_end     = END_MARKER_RESET;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_fetch(7'd64);
    send_rx(cur_start); send_rx(8'hFF); send_rx(8'h42); send_rx(cur_end);
    send_fetch(7'd127);
    send_rx(cur_start); send_rx(8'h00); send_rx(8'h78); send_rx(cur_end);
    send_fetch(7'd5);
    send_rx(cur_start); send_rx(8'h61); send_rx(8'h62); send_rx(8'h63); send_rx(cur_end);
    send_fetch(7'd2);
    send_rx(cur_start); send_rx(cur_end);
    send_fetch(7'd0);
    send_rx(cur_start); send_rx(8'h61); send_rx(cur_start); send_rx(8'h62); send_rx(cur_end);
    send_fetch(7'd1);
    drain();

    write_reg(CFG_START_MARKER, 8'h00);
    write_reg(CFG_END_MARKER, 8'hFF);
    random_burst(20);
    drain();

    write_reg(CFG_START_MARKER, 8'hFF);
    write_reg(CFG_END_MARKER, 8'h00);
    random_burst(20);
    drain();

    write_reg(CFG_START_MARKER, 8'h5A);
    write_reg(CFG_END_MARKER, 8'h5A);
    random_burst(15);
    drain();

    repeat (2) begin
      write_reg(CFG_START_MARKER, 8'($urandom_range(0, 255)));
      write_reg(CFG_END_MARKER, 8'($urandom_range(0, 255)));
      random_burst(15);
      drain();
    end

    write_reg(CFG_START_MARKER, START_MARKER_RESET);
    write_reg(CFG_END_MARKER, END_MARKER_RESET);
    quiet = 1'b1;
    random_burst(20);
    drain();

    repeat (10) @(posedge clk);
    if (fail_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

/* marker_framed_packet_receiver.f */
rtl/core/mfpr_pkg.sv
rtl/core/mfpr_front.sv
rtl/core/mfpr_back.sv
rtl/core/marker_framed_packet_receiver.sv
tb/sv/marker_framed_packet_receiver_checker.sv
tb/sv/marker_framed_packet_receiver_tb.sv
